// File: rtl/gtg_pkg.sv
package gtg_pkg;

	// CORDIC depth and arctangent table length
	localparam int CORDIC_STAGES = 16;
	localparam int TABLE_LEN = 24;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// datapath widths
	localparam int POS_W = 16;
	localparam int DIFF_W = POS_W + 1;
	localparam int GUARD_BITS = 8;
	localparam int XW = 28;
	localparam int ZW = 20;
	localparam int DW = 18;
	localparam int GAIN_W = 12;
	localparam int OUT_W = 15;
	localparam int KGAIN_W = 24;

	// CORDIC gain correction 0.6072529350 in Q24, and pi in Q16
	localparam logic [KGAIN_W-1:0] KGAIN_Q24 = 24'd10188014;
	localparam logic signed [ZW-1:0] PI_Q16 = 20'sd205887;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_TARGET_X = 3'd0,
		REG_TARGET_Y = 3'd1,
		REG_SPEED_GAIN = 3'd2,
		REG_MAX_SPEED = 3'd3,
		REG_ARRIVE_DIST = 3'd4,
		REG_TURN_THRESH = 3'd5
	} reg_idx_t;

	// word held in the queue: pre-rotated vector, start angle, heading
	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic signed [POS_W-1:0] hd;
	} q_word_t;

	// control registers seen by the back end
	typedef struct packed {
		logic [GAIN_W-1:0] speed_gain;
		logic [OUT_W-1:0] max_linear_speed;
		logic [OUT_W-1:0] arrive_distance;
		logic [OUT_W-1:0] turn_threshold;
	} cfg_t;

	// arctangent of 2^-i in units of 2^-16 rad, rounded to nearest
	function automatic logic signed [ZW-1:0] atan_q16(input int i);
		logic signed [ZW-1:0] r;
		case (i)
			0: r = 20'sd51472;
			1: r = 20'sd30386;
			2: r = 20'sd16055;
			3: r = 20'sd8150;
			4: r = 20'sd4091;
			5: r = 20'sd2047;
			6: r = 20'sd1024;
			7: r = 20'sd512;
			8: r = 20'sd256;
			9: r = 20'sd128;
			10: r = 20'sd64;
			11: r = 20'sd32;
			12: r = 20'sd16;
			13: r = 20'sd8;
			14: r = 20'sd4;
			15: r = 20'sd2;
			16: r = 20'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/go_to_goal_speed_controller.sv
// Proportional go-to-goal controller. Pulse start with a pose (pos_x, pos_y
// in Q4.11, heading in Q3.12 rad) while busy is low; one result follows on
// linear_speed (Q4.11) and turn_rate (Q3.12), marked by a one-cycle done
// strobe that cannot be held off. A new pose may be started every cycle; the
// result passes through the input register, the queue, the unrolled CORDIC
// (one micro-rotation per stage) and finally through the multiply and
// limit stages behind it. busy rises only if the queue between the input
// stage and the CORDIC fills, which the back end's steady draining prevents.
// Outside the arrive radius the block turns in place (turn_rate = |bearing -
// heading|, unwrapped) when that error exceeds turn_threshold, and otherwise
// drives at speed_gain * distance / 256 limited to max_linear_speed. Configuration
// (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready and must be
// written only while no pose is in flight; unknown indexes are ignored.
module go_to_goal_speed_controller #(
	parameter int CORDIC_STAGES = gtg_pkg::CORDIC_STAGES
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] heading,
	output logic done,
	output logic [14:0] linear_speed,
	output logic [14:0] turn_rate,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [15:0] cfg_data
);

	logic signed [15:0] target_x_q, target_y_q;
	gtg_pkg::cfg_t cfg_q;
	logic full, empty, push, pop;
	gtg_pkg::q_word_t push_word, pop_word;

	// control registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_x_q <= 16'sd20480;
			target_y_q <= 16'sd20480;
			cfg_q.speed_gain <= 12'd256;
			cfg_q.max_linear_speed <= 15'd6144;
			cfg_q.arrive_distance <= 15'd205;
			cfg_q.turn_threshold <= 15'd819;
		end else if (cfg_valid && cfg_ready) begin
			case (gtg_pkg::reg_idx_t'(cfg_index))
				gtg_pkg::REG_TARGET_X: target_x_q <= cfg_data;
				gtg_pkg::REG_TARGET_Y: target_y_q <= cfg_data;
				gtg_pkg::REG_SPEED_GAIN: cfg_q.speed_gain <= cfg_data[11:0];
				gtg_pkg::REG_MAX_SPEED: cfg_q.max_linear_speed <= cfg_data[14:0];
				gtg_pkg::REG_ARRIVE_DIST: cfg_q.arrive_distance <= cfg_data[14:0];
				gtg_pkg::REG_TURN_THRESH: cfg_q.turn_threshold <= cfg_data[14:0];
				default: begin
				end
			endcase
		end
	end

	gtg_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.heading(heading),
		.target_x(target_x_q),
		.target_y(target_y_q),
		.full(full),
		.push(push),
		.word(push_word)
	);

	gtg_fifo #(
		.DEPTH(gtg_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.word_in(push_word),
		.pop(pop),
		.word_out(pop_word),
		.full(full),
		.empty(empty)
	);

	gtg_back #(
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.empty(empty),
		.word(pop_word),
		.pop(pop),
		.cfg(cfg_q),
		.done(done),
		.linear_speed(linear_speed),
		.turn_rate(turn_rate)
	);

endmodule

// File: rtl/gtg_front.sv
module gtg_front (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [gtg_pkg::POS_W-1:0] pos_x,
	input  logic signed [gtg_pkg::POS_W-1:0] pos_y,
	input  logic signed [gtg_pkg::POS_W-1:0] heading,
	input  logic signed [gtg_pkg::POS_W-1:0] target_x,
	input  logic signed [gtg_pkg::POS_W-1:0] target_y,
	input  logic full,
	output logic push,
	output gtg_pkg::q_word_t word
);

	localparam int DIFF_W = gtg_pkg::DIFF_W;
	localparam int XW = gtg_pkg::XW;
	localparam int ZW = gtg_pkg::ZW;

	logic signed [DIFF_W-1:0] dx, dy, xm, ym;
	logic signed [XW-1:0] xe, ye;
	logic signed [ZW-1:0] z0;
	logic behind;
	logic valid_s1;
	gtg_pkg::q_word_t word_s1;

	// vector to the target
	assign dx = DIFF_W'(target_x) - DIFF_W'(pos_x);
	assign dy = DIFF_W'(target_y) - DIFF_W'(pos_y);

	// target behind: turn by pi (or -pi) into the right half plane
	assign behind = dx < 0;
	assign xm = behind ? -dx : dx;
	assign ym = behind ? -dy : dy;
	assign z0 = !behind ? '0 : ((dy >= 0) ? gtg_pkg::PI_Q16 : -gtg_pkg::PI_Q16);
	assign xe = XW'(xm) <<< gtg_pkg::GUARD_BITS;
	assign ye = XW'(ym) <<< gtg_pkg::GUARD_BITS;

	// stalls only while the held word cannot enter the queue
	assign busy = valid_s1 && full;
	assign push = valid_s1 && !full;
	assign word = word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!busy) begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (!busy && start) begin
			word_s1.x <= xe;
			word_s1.y <= ye;
			word_s1.z <= z0;
			word_s1.hd <= heading;
		end
	end

endmodule

// File: rtl/gtg_fifo.sv
module gtg_fifo #(
	parameter int DEPTH = gtg_pkg::QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  gtg_pkg::q_word_t word_in,
	input  logic pop,
	output gtg_pkg::q_word_t word_out,
	output logic full,
	output logic empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	gtg_pkg::q_word_t mem_q [0:DEPTH-1];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full = count_q == CW'(DEPTH);
	assign empty = count_q == '0;
	assign word_out = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= word_in;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("word pushed into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("word popped from empty queue");
	a_count_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count missed a push");
`endif

endmodule

// File: rtl/gtg_back.sv
module gtg_back #(
	parameter int CORDIC_STAGES = gtg_pkg::CORDIC_STAGES
) (
	input  logic clk,
	input  logic arst_n,
	input  logic empty,
	input  gtg_pkg::q_word_t word,
	output logic pop,
	input  gtg_pkg::cfg_t cfg,
	output logic done,
	output logic [gtg_pkg::OUT_W-1:0] linear_speed,
	output logic [gtg_pkg::OUT_W-1:0] turn_rate
);

	localparam int N = CORDIC_STAGES;
	localparam int XW = gtg_pkg::XW;
	localparam int ZW = gtg_pkg::ZW;
	localparam int DW = gtg_pkg::DW;
	localparam int GW = gtg_pkg::GAIN_W;
	localparam int OW = gtg_pkg::OUT_W;
	localparam int PW = XW - 1 + gtg_pkg::KGAIN_W;
	localparam int LW = DW + GW;
	localparam logic [PW:0] ROUND = (PW + 1)'(1) << 31;
	localparam logic [ZW-1:0] TURN_MAX = ZW'((1 << OW) - 1);

	// CORDIC pipeline registers, index 0 is the word taken from the queue
	logic signed [XW-1:0] cx_s [0:N];
	logic signed [XW-1:0] cy_s [0:N];
	logic signed [ZW-1:0] cz_s [0:N];
	logic signed [gtg_pkg::POS_W-1:0] hd_s [0:N];
	logic vld_s [0:N];

	// post-processing stages
	logic [PW-1:0] prod_s1;
	logic [ZW-1:0] err_s1, err_s2;
	logic [DW-1:0] dist_s2;
	logic [LW-1:0] linp_s3;
	logic [OW-1:0] turnv_s3;
	logic drive_s3, turn_s3;
	logic vld_s1, vld_s2, vld_s3;
	logic done_q;
	logic [OW-1:0] linear_speed_q, turn_rate_q;

	logic [XW-2:0] xc;
	logic signed [ZW-1:0] zr;
	logic signed [ZW:0] e;
	logic [LW-9:0] lin;
	logic [OW-1:0] lin_sat;

	// queue never backs up: one word leaves each cycle it is there
	assign pop = !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= pop;
		end
	end

	always_ff @(posedge clk) begin
		cx_s[0] <= word.x;
		cy_s[0] <= word.y;
		cz_s[0] <= word.z;
		hd_s[0] <= word.hd;
	end

	// one micro-rotation per stage, driving y toward zero
	for (genvar g = 0; g < N; g++) begin : g_rot
		logic signed [XW-1:0] xs, ys;
		assign xs = cx_s[g] >>> g;
		assign ys = cy_s[g] >>> g;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (cy_s[g] >= 0) begin
				cx_s[g+1] <= cx_s[g] + ys;
				cy_s[g+1] <= cy_s[g] - xs;
				cz_s[g+1] <= cz_s[g] + gtg_pkg::atan_q16(g);
			end else begin
				cx_s[g+1] <= cx_s[g] - ys;
				cy_s[g+1] <= cy_s[g] + xs;
				cz_s[g+1] <= cz_s[g] - gtg_pkg::atan_q16(g);
			end
			hd_s[g+1] <= hd_s[g];
		end
	end

	// stage 1: gain correction product, absolute heading error
	assign xc = cx_s[N][XW-1] ? '0 : cx_s[N][XW-2:0];
	assign zr = (cz_s[N] + ZW'(8)) >>> 4;
	assign e = (ZW + 1)'(zr) - (ZW + 1)'(hd_s[N]);

	always_ff @(posedge clk) begin
		prod_s1 <= PW'(xc) * PW'(gtg_pkg::KGAIN_Q24);
		err_s1 <= e[ZW] ? ZW'(-e) : ZW'(e);
	end

	// stage 2: round distance to Q4.11
	always_ff @(posedge clk) begin
		dist_s2 <= DW'(((PW + 1)'(prod_s1) + ROUND) >> 32);
		err_s2 <= err_s1;
	end

	// stage 3: pick turn or drive, scale distance by gain
	always_ff @(posedge clk) begin
		linp_s3 <= LW'(dist_s2) * LW'(cfg.speed_gain);
		turnv_s3 <= (err_s2 > TURN_MAX) ? OW'(TURN_MAX) : err_s2[OW-1:0];
		turn_s3 <= (dist_s2 > DW'(cfg.arrive_distance)) &&
			(err_s2 > ZW'(cfg.turn_threshold));
		drive_s3 <= (dist_s2 > DW'(cfg.arrive_distance)) &&
			!(err_s2 > ZW'(cfg.turn_threshold));
	end

	// stage 4: speed limit and result register
	assign lin = linp_s3[LW-1:8];
	assign lin_sat = (lin > (LW - 8)'(cfg.max_linear_speed)) ? cfg.max_linear_speed
		: lin[OW-1:0];

	always_ff @(posedge clk) begin
		linear_speed_q <= drive_s3 ? lin_sat : '0;
		turn_rate_q <= turn_s3 ? turnv_s3 : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= vld_s[N];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			done_q <= vld_s3;
		end
	end

	assign done = done_q;
	assign linear_speed = linear_speed_q;
	assign turn_rate = turn_rate_q;

`ifndef SYNTH
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$past(pop, N + 5) |-> done_q)
		else $error("result strobe missing after queue pop");
	a_no_stray_done: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(pop, N + 5))
		else $error("result strobe out of step with queue pop");
	a_one_command: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (linear_speed_q == '0) || (turn_rate_q == '0))
		else $error("turn and drive commanded together");
	a_speed_limit: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> linear_speed_q <= cfg.max_linear_speed)
		else $error("linear speed above limit");
`endif

endmodule

// File: tb/sv/go_to_goal_speed_controller_tb.sv
module go_to_goal_speed_controller_tb;
	import gtg_pkg::*;

	// index codes that map to no register; writes to them must be ignored
	localparam logic [2:0] REG_UNMAPPED_A = 3'd6;
	localparam logic [2:0] REG_UNMAPPED_B = 3'd7;

	localparam int SETTLE = CORDIC_STAGES + 15;
	localparam int QUIET_LIMIT = 4000;
	localparam int PHASES = 10;
	localparam int POSES_PER_PHASE = 115;

	// arctangent of 2^-i, units of 2^-16 rad
	localparam longint ATAN_STEP [24] = '{
		51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2,
		1, 0, 0, 0, 0, 0, 0, 0
	};

	typedef struct packed {
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [15:0] hd;
	} pose_t;

	typedef struct packed {
		logic [14:0] lin;
		logic [14:0] turn;
	} cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [15:0] pos_x = '0;
	logic signed [15:0] pos_y = '0;
	logic signed [15:0] heading = '0;
	logic done;
	logic [14:0] linear_speed;
	logic [14:0] turn_rate;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// shadow copy of the control registers
	logic signed [15:0] goal_x = 16'sd20480;
	logic signed [15:0] goal_y = 16'sd20480;
	logic [11:0] gain = 12'd256;
	logic [14:0] vmax = 15'd6144;
	logic [14:0] r_arrive = 15'd205;
	logic [14:0] turn_lim = 15'd819;

	pose_t pose_q[$];
	cmd_t cmd_exp_q[$];
	pose_t cur_pose = '0;
	int n_taken = 0;
	int n_bad = 0;
	int quiet = 0;

	go_to_goal_speed_controller uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.heading(heading),
		.done(done),
		.linear_speed(linear_speed),
		.turn_rate(turn_rate),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic signed [15:0] sat16(input longint v);
		if (v > 32767) return 16'sd32767;
		if (v < -32768) return -16'sd32768;
		return v[15:0];
	endfunction

	function automatic logic signed [15:0] corner_value();
		case ($urandom_range(0, 3))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return 16'sd0;
			default: return -16'sd1;
		endcase
	endfunction

	// distance (Q4.11) and bearing (Q3.12) from a position to the goal
	function automatic void goal_polar(input logic signed [15:0] px,
			input logic signed [15:0] py, output longint dlen, output longint bearing);
		longint dx, dy, x, y, z, xs, ys;
		int i;
		dx = longint'(goal_x) - longint'(px);
		dy = longint'(goal_y) - longint'(py);
		z = 0;
		// goal behind: pre-rotate by pi so vectoring converges
		if (dx < 0) begin
			z = (dy >= 0) ? longint'(PI_Q16) : -longint'(PI_Q16);
			dx = -dx;
			dy = -dy;
		end
		x = dx * 256;
		y = dy * 256;
		for (i = 0; i < CORDIC_STAGES && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + ATAN_STEP[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - ATAN_STEP[i];
			end
		end
		if (x < 0) x = 0;
		dlen = (x * longint'(KGAIN_Q24) + (64'sd1 <<< 31)) >>> 32;
		bearing = (z + 8) >>> 4;
	endfunction

	// speed command expected for one pose under the current settings
	function automatic cmd_t predict_cmd(input pose_t p);
		longint dlen, bearing, err, lin, turn;
		cmd_t c;
		goal_polar(p.px, p.py, dlen, bearing);
		err = bearing - longint'(p.hd);
		if (err < 0) err = -err;
		lin = 0;
		turn = 0;
		if (dlen > longint'(r_arrive)) begin
			if (err > longint'(turn_lim))
				turn = (err > 32767) ? 32767 : err;
			else
				lin = (dlen * longint'(gain)) >>> 8;
		end
		if (lin > longint'(vmax)) lin = longint'(vmax);
		c.lin = lin[14:0];
		c.turn = turn[14:0];
		return c;
	endfunction

	// heading pointed at the goal, give or take an offset
	function automatic logic signed [15:0] aim_heading(input logic signed [15:0] px,
			input logic signed [15:0] py, input int off);
		longint dlen, bearing;
		goal_polar(px, py, dlen, bearing);
		return sat16(bearing + off);
	endfunction

	task automatic add_pose(input logic signed [15:0] px, input logic signed [15:0] py,
			input logic signed [15:0] hd);
		pose_t p;
		p.px = px;
		p.py = py;
		p.hd = hd;
		pose_q.push_back(p);
	endtask

	task automatic add_random_pose();
		logic signed [15:0] px, py, hd;
		int m, h, span;
		m = $urandom_range(0, 99);
		if (m < 15) begin
			// close to the goal: arrive radius and short drives
			px = sat16(longint'(goal_x) + int'($urandom_range(0, 800)) - 400);
			py = sat16(longint'(goal_y) + int'($urandom_range(0, 800)) - 400);
		end else if (m < 25) begin
			px = corner_value();
			py = corner_value();
		end else begin
			px = 16'($urandom);
			py = 16'($urandom);
		end
		h = $urandom_range(0, 99);
		if (h < 50) begin
			// roughly aligned, straddling the turn threshold
			span = int'(turn_lim) + 256;
			if (span > 4000) span = 4000;
			hd = aim_heading(px, py, int'($urandom_range(0, 2 * span)) - span);
		end else if (h < 60) begin
			hd = corner_value();
		end else begin
			hd = 16'($urandom);
		end
		add_pose(px, py, hd);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_TARGET_X: goal_x = val;
			REG_TARGET_Y: goal_y = val;
			REG_SPEED_GAIN: gain = val[11:0];
			REG_MAX_SPEED: vmax = val[14:0];
			REG_ARRIVE_DIST: r_arrive = val[14:0];
			REG_TURN_THRESH: turn_lim = val[14:0];
			default: ;
		endcase
	endtask

	// random settings; each register touched with some chance
	task automatic shuffle_settings();
		if ($urandom_range(0, 9) < 6)
			write_reg(REG_TARGET_X,
				($urandom_range(0, 9) < 3) ? corner_value() : 16'($urandom));
		if ($urandom_range(0, 9) < 6)
			write_reg(REG_TARGET_Y,
				($urandom_range(0, 9) < 3) ? corner_value() : 16'($urandom));
		if ($urandom_range(0, 9) < 6)
			write_reg(REG_SPEED_GAIN, 16'($urandom));
		if ($urandom_range(0, 9) < 6)
			write_reg(REG_MAX_SPEED, 16'($urandom));
		if ($urandom_range(0, 9) < 6)
			write_reg(REG_ARRIVE_DIST,
				($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 2000)) : 16'($urandom));
		if ($urandom_range(0, 9) < 6)
			write_reg(REG_TURN_THRESH,
				($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 6000)) : 16'($urandom));
		if ($urandom_range(0, 9) < 3)
			write_reg(($urandom_range(0, 1) != 0) ? REG_UNMAPPED_A : REG_UNMAPPED_B,
				16'($urandom));
	endtask

	// wait for every pose to be taken and answered, then let the pipe settle
	task automatic drain();
		while (pose_q.size() != 0 || start || cmd_exp_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic flag(input string msg);
		n_bad++;
		if (n_bad <= 10) $display("%s", msg);
	endtask

	// pose driver
	always @(posedge clk or negedge arst_n) begin : drive
		logic launch;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			launch = start;
			if (start && !busy) begin
				cmd_exp_q.push_back(predict_cmd(cur_pose));
				n_taken++;
				launch = 1'b0;
			end
			// gaps everywhere except one long burst
			if (!launch && pose_q.size() != 0 &&
					!(($urandom_range(0, 99) < 38) && !(n_taken >= 500 && n_taken < 800))) begin
				cur_pose = pose_q.pop_front();
				pos_x <= cur_pose.px;
				pos_y <= cur_pose.py;
				heading <= cur_pose.hd;
				launch = 1'b1;
			end
			start <= launch;
		end
	end

	// result monitor
	always @(posedge clk) begin : watch_results
		cmd_t want;
		if (arst_n && done) begin
			if (cmd_exp_q.size() == 0) begin
				flag($sformatf("unexpected word: linear_speed %0d turn_rate %0d",
					linear_speed, turn_rate));
			end else begin
				want = cmd_exp_q.pop_front();
				if (linear_speed !== want.lin)
					flag($sformatf("linear_speed: expected %0d, got %0d", want.lin, linear_speed));
				if (turn_rate !== want.turn)
					flag($sformatf("turn_rate: expected %0d, got %0d", want.turn, turn_rate));
			end
		end
	end

	// watchdog on cycles with no traffic at all
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin : stim
		int ph, k;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed poses at reset settings
		add_pose(16'sd20480, 16'sd20480, 16'sd0);
		add_pose(16'sd20580, 16'sd20380, 16'sd0);
		add_pose(16'sd20180, 16'sd20480, 16'sd0);
		add_pose(16'sd0, 16'sd0, 16'sd3217);
		add_pose(16'sd0, 16'sd0, 16'sd0);
		add_pose(16'sd32767, 16'sd20480, 16'sd12868);
		add_pose(16'sd32767, 16'sd20480, -16'sd12868);
		add_pose(16'sd32767, 16'sd32767, -16'sd9651);
		add_pose(-16'sd32768, -16'sd32768, -16'sd32768);
		add_pose(-16'sd32768, 16'sd32767, 16'sd32767);
		add_pose(16'sd32767, -16'sd32768, 16'sd0);
		add_pose(16'sd32767, -16'sd32768, -16'sd32768);
		add_pose(16'sd0, 16'sd0, aim_heading(16'sd0, 16'sd0, 0));
		add_pose(16'sd0, 16'sd0, aim_heading(16'sd0, 16'sd0, 819));
		add_pose(16'sd0, 16'sd0, aim_heading(16'sd0, 16'sd0, -819));
		add_pose(16'sd0, 16'sd0, aim_heading(16'sd0, 16'sd0, 820));
		add_pose(16'sd0, 16'sd0, aim_heading(16'sd0, 16'sd0, -820));
		add_pose(16'sd30000, 16'sd30000, aim_heading(16'sd30000, 16'sd30000, 0));
		add_pose(16'sd20000, 16'sd20480, aim_heading(16'sd20000, 16'sd20480, 100));
		add_pose(-16'sd1, -16'sd1, aim_heading(-16'sd1, -16'sd1, -300));
		drain();

		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					// far corner goal, full gain, no arrive radius, turn on any heading error
					write_reg(REG_TARGET_X, 16'h8000);
					write_reg(REG_TARGET_Y, 16'h8000);
					write_reg(REG_SPEED_GAIN, 16'h0FFF);
					write_reg(REG_MAX_SPEED, 16'h7FFF);
					write_reg(REG_ARRIVE_DIST, 16'h0000);
					write_reg(REG_TURN_THRESH, 16'h0000);
				end
				1: begin
					write_reg(REG_TARGET_X, 16'h7FFF);
					write_reg(REG_TARGET_Y, 16'h7FFF);
					write_reg(REG_SPEED_GAIN, 16'h0000);
					write_reg(REG_MAX_SPEED, 16'h0000);
					write_reg(REG_ARRIVE_DIST, 16'h7FFF);
					write_reg(REG_TURN_THRESH, 16'h7FFF);
				end
				2: begin
					// drive unless the heading error exceeds the largest threshold, saturating speed
					write_reg(REG_TARGET_X, 16'h7FFF);
					write_reg(REG_TARGET_Y, 16'h8000);
					write_reg(REG_SPEED_GAIN, 16'hFFFF);
					write_reg(REG_MAX_SPEED, 16'hFFFF);
					write_reg(REG_ARRIVE_DIST, 16'h8000);
					write_reg(REG_TURN_THRESH, 16'hFFFF);
					write_reg(REG_UNMAPPED_A, 16'hFFFF);
					write_reg(REG_UNMAPPED_B, 16'h0000);
				end
				3: begin
					write_reg(REG_TARGET_X, 16'sd20480);
					write_reg(REG_TARGET_Y, -16'sd20480);
					write_reg(REG_SPEED_GAIN, 16'd256);
					write_reg(REG_MAX_SPEED, 16'd6144);
					write_reg(REG_ARRIVE_DIST, 16'd205);
					write_reg(REG_TURN_THRESH, 16'd819);
				end
				default: shuffle_settings();
			endcase
			for (k = 0; k < POSES_PER_PHASE; k++)
				add_random_pose();
			drain();
		end

		if (n_bad == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
